// ----- src/fbfla_pkg.sv -----
// ---------------------------------------------------------------------------
// fbfla_pkg
// Shared types, constants and helpers of the fixed block free list allocator.
// ---------------------------------------------------------------------------
package fbfla_pkg;

    localparam int MAX_BLOCKS_DEF = 256;
    localparam int WORD_BYTES_DEF = 8;

    localparam int CNT_CFG_W   = 9;
    localparam int BYTES_CFG_W = 13;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_IDX_W   = 1;
    localparam int OPC_W       = 2;
    localparam int BIDX_W      = 8;
    localparam int STAT_W      = 2;
    localparam int GIDX_W      = 8;
    localparam int OFF_W       = 21;
    localparam int FCNT_W      = 9;

    localparam int S_TDATA_W = 8;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    localparam int COUNT_RST    = 256;
    localparam int BYTES_RST    = 8;
    localparam int BYTES_LIMIT  = 4096;
    localparam int RECIP_SHIFT  = 16;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = 1'd1;

    typedef enum logic [OPC_W-1:0] {
        OP_ALLOC  = 2'd0,
        OP_FREE   = 2'd1,
        OP_REINIT = 2'd2,
        OP_NONE   = 2'd3
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_NULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        K_ALLOC,
        K_FREE,
        K_NULL_FREE,
        K_REINIT,
        K_NOP
    } t_kind;

    typedef enum logic {
        BS_IDLE,
        BS_POP
    } t_back_state;

    typedef struct packed {
        t_kind              kind;
        logic [BIDX_W-1:0]  idx;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_slot;

    typedef struct packed {
        t_status            status;
        logic [GIDX_W-1:0]  gidx;
        logic [OFF_W-1:0]   off;
        logic [FCNT_W-1:0]  fcnt;
    } t_result;

    // clamp to [word, limit] and round up to a whole number of words;
    // recip is ceil(2^RECIP_SHIFT / word), exact for all sizes in range
    function automatic logic [BYTES_CFG_W-1:0] f_stride(
        input logic [BYTES_CFG_W-1:0] bytes,
        input int                     word,
        input int                     recip
    );
        logic [BYTES_CFG_W-1:0] sz;
        logic [BYTES_CFG_W:0]   up;
        logic [31:0]            prod;
        logic [BYTES_CFG_W-1:0] q;
        sz = bytes;
        if (sz > BYTES_CFG_W'(BYTES_LIMIT)) begin
            sz = BYTES_CFG_W'(BYTES_LIMIT);
        end
        if (sz < BYTES_CFG_W'(word)) begin
            sz = BYTES_CFG_W'(word);
        end
        up   = (BYTES_CFG_W + 1)'(sz) + (BYTES_CFG_W + 1)'(word - 1);
        prod = 32'(up) * 32'(recip);
        q    = BYTES_CFG_W'(prod >> RECIP_SHIFT);
        return BYTES_CFG_W'(32'(q) * 32'(word));
    endfunction

endpackage

// ----- src/fbfla_front.sv -----
// ---------------------------------------------------------------------------
// fbfla_front
// Input register: takes items off the slave stream and classifies them.
// ---------------------------------------------------------------------------
module fbfla_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [fbfla_pkg::S_TDATA_W-1:0]    i_s_tdata,  // block_index
    input  logic [fbfla_pkg::S_TUSER_W-1:0]    i_s_tuser,  // opcode, is_null
    input  logic                               i_q_full,
    output fbfla_pkg::t_q_slot                 o_push
);
    import fbfla_pkg::*;

    logic  r_valid;
    t_cmd  r_cmd;
    t_cmd  n_cmd;
    logic  accept;
    logic  push;

    assign push       = r_valid && !i_q_full;
    assign o_s_tready = !r_valid || !i_q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_cmd.idx = i_s_tdata[BIDX_W-1:0];
        case (t_opcode'(i_s_tuser[OPC_W-1:0]))
            OP_ALLOC:  n_cmd.kind = K_ALLOC;
            OP_FREE:   n_cmd.kind = i_s_tuser[OPC_W] ? K_NULL_FREE : K_FREE;
            OP_REINIT: n_cmd.kind = K_REINIT;
            default:   n_cmd.kind = K_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd <= n_cmd;
        end
    end

    assign o_push.valid = push;
    assign o_push.cmd   = r_cmd;

endmodule

// ----- src/fbfla_queue.sv -----
// ---------------------------------------------------------------------------
// fbfla_queue
// Two-entry command queue between the front and the execution unit.
// ---------------------------------------------------------------------------
module fbfla_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  fbfla_pkg::t_q_slot  i_push,
    output logic                o_full,
    output fbfla_pkg::t_q_slot  o_head,
    input  logic                i_pop
);
    import fbfla_pkg::*;

    t_cmd        r_mem [2];
    logic        r_wp;
    logic        r_rp;
    logic [1:0]  r_cnt;
    logic        do_push;
    logic        do_pop;

    assign o_full       = r_cnt == 2'd2;
    assign do_push      = i_push.valid && !o_full;
    assign do_pop       = i_pop && (r_cnt != 2'd0);
    assign o_head.valid = r_cnt != 2'd0;
    assign o_head.cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= !r_wp;
            end
            if (do_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(do_push) - 2'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_push.cmd;
        end
    end

endmodule

// ----- src/fbfla_back.sv -----
// ---------------------------------------------------------------------------
// fbfla_back
// Execution unit: link memory, list head, free count and result register.
// ---------------------------------------------------------------------------
module fbfla_back #(
    parameter int MAX_BLOCKS = fbfla_pkg::MAX_BLOCKS_DEF,
    parameter int WORD_BYTES = fbfla_pkg::WORD_BYTES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  fbfla_pkg::t_q_slot                  i_head,
    output logic                                o_pop,
    input  logic [fbfla_pkg::CNT_CFG_W-1:0]     i_block_count,
    input  logic [fbfla_pkg::BYTES_CFG_W-1:0]   i_block_bytes,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output fbfla_pkg::t_result                  o_res
);
    import fbfla_pkg::*;

    localparam int IDX_W  = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int PROD_W = IDX_W + BYTES_CFG_W;
    localparam int RECIP  = (2 ** RECIP_SHIFT + WORD_BYTES - 1) / WORD_BYTES;
    localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0] POOL_RST =
        (COUNT_RST > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS) : CNT_W'(COUNT_RST);
    localparam logic [BYTES_CFG_W-1:0] STRIDE_RST =
        f_stride(BYTES_CFG_W'(BYTES_RST), WORD_BYTES, RECIP);

    logic [IDX_W-1:0]        r_link_mem [MAX_BLOCKS];
    logic [IDX_W-1:0]        r_rd_link;
    logic [MAX_BLOCKS-1:0]   r_valid, n_valid;

    t_back_state             r_state, n_state;
    logic [IDX_W-1:0]        r_head, n_head;
    logic [CNT_W-1:0]        r_free, n_free;
    logic [CNT_W-1:0]        r_pool, n_pool;
    logic [BYTES_CFG_W-1:0]  r_stride, n_stride;
    logic [IDX_W-1:0]        r_blk, n_blk;
    logic                    r_out_valid, n_out_valid;
    t_result                 r_res, n_res;

    logic                    out_free;
    logic                    mem_we;
    logic [IDX_W-1:0]        mem_waddr;
    logic                    mem_re;
    logic [CNT_W-1:0]        blk_next;
    logic [IDX_W-1:0]        fresh_link;
    logic [IDX_W-1:0]        pop_link;
    logic [PROD_W-1:0]       blk_off;
    logic [CNT_W-1:0]        pool_new;
    logic [IDX_W-1:0]        free_idx;

    assign out_free = !r_out_valid || i_res_ready;
    assign pool_new = (32'(i_block_count) > 32'(MAX_BLOCKS)) ? MAX_CNT
                                                             : CNT_W'(i_block_count);
    assign free_idx = IDX_W'(i_head.cmd.idx);

    // entry never written since reinit holds the ascending chain
    assign blk_next   = CNT_W'(r_blk) + CNT_W'(1);
    assign fresh_link = (blk_next < r_pool) ? IDX_W'(blk_next) : '0;
    assign pop_link   = r_valid[r_blk] ? r_rd_link : fresh_link;
    assign blk_off    = PROD_W'(r_blk) * PROD_W'(r_stride) + PROD_W'(2 * WORD_BYTES);

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_free      = r_free;
        n_pool      = r_pool;
        n_stride    = r_stride;
        n_blk       = r_blk;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !i_res_ready;
        n_res       = r_res;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = free_idx;
        mem_re      = 1'b0;

        case (r_state)
            BS_IDLE: begin
                if (i_head.valid) begin
                    if (i_head.cmd.kind == K_ALLOC && r_free != '0) begin
                        o_pop   = 1'b1;
                        mem_re  = 1'b1;
                        n_blk   = r_head;
                        n_state = BS_POP;
                    end else if (out_free) begin
                        o_pop       = 1'b1;
                        n_out_valid = 1'b1;
                        n_res       = '{status: ST_OK, gidx: '0, off: '0,
                                        fcnt: FCNT_W'(r_free)};
                        case (i_head.cmd.kind)
                            K_ALLOC: begin
                                n_res.status = ST_EMPTY;
                            end
                            K_FREE: begin
                                if (32'(i_head.cmd.idx) < 32'(r_pool)) begin
                                    mem_we            = 1'b1;
                                    n_valid[free_idx] = 1'b1;
                                    n_head            = free_idx;
                                    if (r_free < MAX_CNT) begin
                                        n_free = r_free + CNT_W'(1);
                                    end
                                    n_res.fcnt = FCNT_W'(n_free);
                                end else begin
                                    n_res.status = ST_RANGE;
                                end
                            end
                            K_NULL_FREE: begin
                                n_res.status = ST_NULL;
                            end
                            K_REINIT: begin
                                n_valid    = '0;
                                n_head     = '0;
                                n_free     = pool_new;
                                n_pool     = pool_new;
                                n_stride   = f_stride(i_block_bytes, WORD_BYTES, RECIP);
                                n_res.fcnt = FCNT_W'(pool_new);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
            end
            BS_POP: begin
                if (out_free) begin
                    n_head      = pop_link;
                    n_free      = r_free - CNT_W'(1);
                    n_out_valid = 1'b1;
                    n_res       = '{status: ST_OK, gidx: GIDX_W'(r_blk),
                                    off: OFF_W'(blk_off),
                                    fcnt: FCNT_W'(r_free - CNT_W'(1))};
                    n_state     = BS_IDLE;
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_head      <= '0;
            r_free      <= POOL_RST;
            r_pool      <= POOL_RST;
            r_stride    <= STRIDE_RST;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_free      <= n_free;
            r_pool      <= n_pool;
            r_stride    <= n_stride;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_blk <= n_blk;
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_link_mem[mem_waddr] <= r_head;
        end
        if (mem_re) begin
            r_rd_link <= r_link_mem[r_head];
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_res;

endmodule

// ----- src/fixed_block_free_list_allocator.sv -----
// ---------------------------------------------------------------------------
// fixed_block_free_list_allocator
// LIFO free list over a pool of equal blocks: allocate, free, reinitialize.
// ---------------------------------------------------------------------------
// Each item gives exactly one result. The execution unit settles a free, a
// reinit, a null or rejected free and an allocate from an empty pool in its
// idle state; an allocate that succeeds passes a second state, BS_POP, that
// waits on the registered read of the link memory. Items pass an input
// register and a two-entry queue before the execution unit, which registers
// its result.
// Out of reset the pool is set up as after a reinit with 256 blocks of
// 8 bytes, with no clearing pass; block_count and block_bytes take effect at
// the next reinit. Double frees are not detected.
module fixed_block_free_list_allocator
    import fbfla_pkg::*;
#(
    parameter int MAX_BLOCKS = MAX_BLOCKS_DEF,
    parameter int WORD_BYTES = WORD_BYTES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [S_TDATA_W-1:0]   i_s_tdata,   // block_index
    input  logic [S_TUSER_W-1:0]   i_s_tuser,   // opcode, is_null
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [M_TDATA_W-1:0]   o_m_tdata,   // granted_index, granted_offset, free_count
    output logic [M_TUSER_W-1:0]   o_m_tuser,   // status
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data
);

    logic [CNT_CFG_W-1:0]    r_block_count;
    logic [BYTES_CFG_W-1:0]  r_block_bytes;
    t_q_slot                 push;
    t_q_slot                 head;
    logic                    q_full;
    logic                    pop;
    t_result                 res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_count <= CNT_CFG_W'(COUNT_RST);
            r_block_bytes <= BYTES_CFG_W'(BYTES_RST);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_BLOCK_COUNT: r_block_count <= i_cfg_data[CNT_CFG_W-1:0];
                REG_BLOCK_BYTES: r_block_bytes <= i_cfg_data[BYTES_CFG_W-1:0];
                default: begin
                end
            endcase
        end
    end

    fbfla_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_q_full   (q_full),
        .o_push     (push)
    );

    fbfla_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (q_full),
        .o_head  (head),
        .i_pop   (pop)
    );

    fbfla_back #(
        .MAX_BLOCKS (MAX_BLOCKS),
        .WORD_BYTES (WORD_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_block_count (r_block_count),
        .i_block_bytes (r_block_bytes),
        .o_res_valid   (o_m_tvalid),
        .i_res_ready   (i_m_tready),
        .o_res         (res)
    );

    assign o_m_tuser = res.status;
    assign o_m_tdata = {(M_TDATA_W - GIDX_W - OFF_W - FCNT_W)'(0), res.fcnt, res.off, res.gidx};

endmodule

// ----- src/fbfla_checker.sv -----
// ---------------------------------------------------------------------------
// fbfla_checker
// Port-level checks on the result stream of the allocator.
// ---------------------------------------------------------------------------
module fbfla_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    input  logic [fbfla_pkg::M_TDATA_W-1:0]     o_m_tdata,  // granted_index, granted_offset, free_count
    input  logic [fbfla_pkg::M_TUSER_W-1:0]     o_m_tuser   // status
);
    import fbfla_pkg::*;

    logic [GIDX_W-1:0] gidx;
    logic [OFF_W-1:0]  off;
    logic [FCNT_W-1:0] fcnt;

    assign gidx = o_m_tdata[GIDX_W-1:0];
    assign off  = o_m_tdata[GIDX_W+OFF_W-1:GIDX_W];
    assign fcnt = o_m_tdata[GIDX_W+OFF_W+FCNT_W-1:GIDX_W+OFF_W];

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("result changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser == ST_EMPTY |-> gidx == '0 && off == '0 && fcnt == '0)
        else $error("empty result with nonzero fields");

    a_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_NULL || o_m_tuser == ST_RANGE)
            |-> gidx == '0 && off == '0)
        else $error("rejected free carries a grant");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> fcnt <= FCNT_W'(MAX_BLOCKS_DEF))
        else $error("free count above pool size");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

endmodule

bind fixed_block_free_list_allocator fbfla_checker u_fbfla_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);
